// ===== design/czm_pkg.sv =====
package czm_pkg;

    localparam int SRC_WIDTH  = 512;
    localparam int SRC_HEIGHT = 512;
    localparam int WIN_SIZE   = 128;

    localparam int COL_W     = $clog2(SRC_WIDTH);
    localparam int ROW_W     = $clog2(SRC_HEIGHT);
    localparam int WIN_W     = $clog2(WIN_SIZE);
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int MIX_W     = PIX_W + 3;
    localparam int BLK_CNT_W = 4;

    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [COORD_W-1:0]   coord_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [WIN_W-1:0]     win_t;

    localparam cfg_idx_t REG_WINDOW_TOP  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_WINDOW_LEFT = cfg_idx_t'(1);

    typedef struct packed {
        pix_t pix;
        pix_t above;
        win_t wrow;
        win_t wcol;
        logic active;
        logic restart;
    } czm_item_t;

    function automatic pix_t mix4(pix_t a, pix_t b, logic [1:0] k);
        logic [2:0]       wa;
        logic [MIX_W-1:0] pa;
        logic [MIX_W-1:0] pb;
        logic [PIX_W:0]   s;
        wa = 3'd4 - {1'b0, k};
        pa = MIX_W'(wa) * MIX_W'(a);
        pb = MIX_W'(k) * MIX_W'(b);
        s  = (PIX_W+1)'(pa >> 2) + (PIX_W+1)'(pb >> 2);
        return s[PIX_W-1:0];
    endfunction

endpackage

// ===== design/czm_if.sv =====
interface czm_in_if;
    logic          valid;
    logic          ready;
    czm_pkg::pix_t pixel_value;
    logic          frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface czm_out_if;
    logic            valid;
    logic            ready;
    czm_pkg::coord_t out_row;
    czm_pkg::coord_t out_col;
    czm_pkg::pix_t   out_value;
    logic            last_of_run;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input last_of_run, output ready);
endinterface

interface czm_cfg_if;
    logic               valid;
    logic               ready;
    czm_pkg::cfg_idx_t  index;
    czm_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/czm_front.sv =====
module czm_front (
    input  logic               clk,
    input  logic               rst_n,
    czm_in_if.sink             pixels,
    input  czm_pkg::cfg_data_t window_top,
    input  czm_pkg::cfg_data_t window_left,
    output logic               item_valid,
    output czm_pkg::czm_item_t item,
    input  logic               item_ready
);
    import czm_pkg::*;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] d;
    logic [ROW_W-1:0] d_m1;
    logic [COL_W-1:0] jd;
    logic             in_win;
    logic             active;
    logic             wr;
    logic             accept;
    win_t             j;

    pix_t mem [WIN_SIZE];
    pix_t above_reg;

    logic s2_v_reg;
    pix_t pix_reg;
    win_t wrow_reg;
    win_t wcol_reg;
    logic active_reg;
    logic restart_reg;

    assign pixels.ready = !s2_v_reg || item_ready;
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        row_cur = pixels.frame_start ? '0 : row_reg;
        col_cur = pixels.frame_start ? '0 : col_reg;
        d       = row_cur - ROW_W'(window_top);
        d_m1    = d - ROW_W'(1);
        jd      = col_cur - COL_W'(window_left);
        j       = jd[WIN_W-1:0];
        in_win  = (row_cur >= ROW_W'(window_top)) && (col_cur >= COL_W'(window_left))
                  && (jd < COL_W'(WIN_SIZE));
        active  = in_win && (d != '0) && (d <= ROW_W'(WIN_SIZE));
        wr      = in_win && (d < ROW_W'(WIN_SIZE));
        if (col_cur == COL_W'(SRC_WIDTH - 1))
        begin
            col_next = '0;
            row_next = (row_cur == ROW_W'(SRC_HEIGHT - 1)) ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                s2_v_reg <= 1'b1;
            end
            else if (item_ready)
            begin
                s2_v_reg <= 1'b0;
            end
        end
    end

    // read the row above before this pixel replaces it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_reg <= mem[j];
            if (wr)
            begin
                mem[j] <= pixels.pixel_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg     <= pixels.pixel_value;
            wrow_reg    <= d_m1[WIN_W-1:0];
            wcol_reg    <= j;
            active_reg  <= active;
            restart_reg <= pixels.frame_start;
        end
    end

    assign item_valid   = s2_v_reg;
    assign item.pix     = pix_reg;
    assign item.above   = above_reg;
    assign item.wrow    = wrow_reg;
    assign item.wcol    = wcol_reg;
    assign item.active  = active_reg;
    assign item.restart = restart_reg;

endmodule

// ===== design/czm_emit.sv =====
module czm_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  czm_pkg::czm_item_t item,
    output logic               item_ready,
    czm_out_if.source          results
);
    import czm_pkg::*;

    logic                 busy_reg;
    logic                 pend_reg;
    logic [BLK_CNT_W-1:0] cnt_reg;
    win_t                 wrow_reg;
    win_t                 wcol_reg;
    pix_t                 blk_l_reg [4];
    pix_t                 blk_r_reg [4];
    pix_t                 prior_reg [4];
    logic                 have_reg;

    logic   out_v_reg;
    coord_t out_row_reg;
    coord_t out_col_reg;
    pix_t   out_value_reg;
    logic   out_last_reg;

    pix_t       v [4];
    logic       step;
    logic       block_end;
    logic       job_end;
    logic       load;
    logic       blk_a;
    logic       blk_b;
    logic [1:0] r;
    logic [1:0] c;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            v[k] = mix4(item.above, item.pix, 2'(k));
        end
    end

    assign step       = busy_reg && (!out_v_reg || results.ready);
    assign block_end  = (cnt_reg == {BLK_CNT_W{1'b1}});
    assign job_end    = block_end && !pend_reg;
    assign item_ready = !busy_reg || (step && job_end);
    assign load       = item_valid && item_ready;
    assign blk_a      = item.active && (item.wcol != '0) && have_reg && !item.restart;
    assign blk_b      = item.active && (item.wcol == win_t'(WIN_SIZE - 1));
    assign r          = cnt_reg[3:2];
    assign c          = cnt_reg[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            have_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= blk_a || blk_b;
                pend_reg <= blk_a && blk_b;
                cnt_reg  <= '0;
                if (item.active)
                begin
                    have_reg <= !blk_b;
                end
                else if (item.restart)
                begin
                    have_reg <= 1'b0;
                end
            end
            else if (step)
            begin
                cnt_reg <= cnt_reg + BLK_CNT_W'(1);
                if (block_end)
                begin
                    pend_reg <= 1'b0;
                    if (!pend_reg)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            if (step)
            begin
                out_v_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            wrow_reg <= item.wrow;
            if (blk_a)
            begin
                blk_l_reg <= prior_reg;
                blk_r_reg <= v;
                wcol_reg  <= item.wcol - win_t'(1);
            end
            else
            begin
                blk_l_reg <= v;
                blk_r_reg <= '{default: '0};
                wcol_reg  <= item.wcol;
            end
            if (item.active && !blk_b)
            begin
                prior_reg <= v;
            end
        end
        else if (step && block_end && pend_reg)
        begin
            // last column: its right neighbour is zero
            blk_l_reg <= blk_r_reg;
            blk_r_reg <= '{default: '0};
            wcol_reg  <= wcol_reg + win_t'(1);
        end

        if (step)
        begin
            out_row_reg   <= COORD_W'({wrow_reg, r});
            out_col_reg   <= COORD_W'({wcol_reg, c});
            out_value_reg <= mix4(blk_l_reg[r], blk_r_reg[r], c);
            out_last_reg  <= job_end;
        end
    end

    assign results.valid       = out_v_reg;
    assign results.out_row     = out_row_reg;
    assign results.out_col     = out_col_reg;
    assign results.out_value   = out_value_reg;
    assign results.last_of_run = out_last_reg;

endmodule

// ===== design/crop_bilinear_zoom_4x_top.sv =====
// channel   dir  handshake      request contents
// pixels    in   valid/ready    pixel_value, frame_start
// results   out  valid/ready    out_row, out_col, out_value, last_of_run
// cfg       in   valid/ready    index, data (0: window_top, 1: window_left)
//
// A pixel that emits no block leaves the emitter idle; one that emits a block yields 16
// requests from the serialiser, 32 at the last window column with a held column, one per
// cycle while results is ready. Prior-row memory is read per pixel, written in the window.
// Reset clears counters, the held column flag and all valid flags; cfg is always ready.
// A stalled results channel holds its request and backs up into pixels after one item.
module crop_bilinear_zoom_4x_top (
    input  logic clk,
    input  logic rst_n,
    czm_in_if.sink    pixels,
    czm_out_if.source results,
    czm_cfg_if.sink   cfg
);
    import czm_pkg::*;

    cfg_data_t window_top_reg;
    cfg_data_t window_left_reg;
    logic      item_valid;
    logic      item_ready;
    czm_item_t item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_top_reg  <= '0;
            window_left_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_WINDOW_TOP:  window_top_reg  <= cfg.data;
                REG_WINDOW_LEFT: window_left_reg <= cfg.data;
                default:         window_top_reg  <= window_top_reg;
            endcase
        end
    end

    czm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels),
        .window_top  (window_top_reg),
        .window_left (window_left_reg),
        .item_valid  (item_valid),
        .item        (item),
        .item_ready  (item_ready)
    );

    czm_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .results    (results)
    );

endmodule

// ===== design/czm_checker.sv =====
module czm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            res_valid,
    input logic            res_ready,
    input czm_pkg::coord_t res_row,
    input czm_pkg::coord_t res_col,
    input czm_pkg::pix_t   res_value,
    input logic            res_last
);
    import czm_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_row) && $stable(res_col)
                                    && $stable(res_value) && $stable(res_last))
        else $error("result request changed while stalled");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_last |-> res_row[1:0] == 2'd3 && res_col[1:0] == 2'd3)
        else $error("run ends away from the block corner");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid)
        else $error("gap inside a run of results");

endmodule

bind crop_bilinear_zoom_4x_top czm_checker u_czm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_row   (results.out_row),
    .res_col   (results.out_col),
    .res_value (results.out_value),
    .res_last  (results.last_of_run)
);
